/* rtl/avt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avt_pkg
// Shared constants for the affine vertex transform: field widths, matrix
// shape, parameter defaults and the request kind codes.
// ----------------------------------------------------------------------------
package avt_pkg;

  // Every payload field on the ports is this wide.
  localparam int FIELD_WIDTH = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  // Three stored rows of four coefficients, row-major.
  localparam int NUM_ROWS  = 3;
  localparam int ROW_LEN   = 4;
  localparam int NUM_COEF  = NUM_ROWS * ROW_LEN;
  localparam int NUM_AXES  = 3;
  localparam int IDX_WIDTH = 4;

  // Request kinds. The fourth code is unused and ignored.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_VECTOR = 2'd2;

endpackage
`default_nettype wire

/* rtl/affine_vertex_transform.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// affine_vertex_transform
// Multiplies vertices by the upper three rows of a 4x4 affine matrix held in
// twelve fixed-point coefficient registers.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid/in_stall with a kind code. A load request writes
// one coefficient (row-major index 0 to 11) and gives no result; indexes 12
// to 15 and the unused kind are dropped. A point request gives rows times
// (x,y,z,1); a vector request leaves out the translation column. u and v are
// copied through. Results leave on out_valid/out_stall.
// The path is three register stages: the nine products, the sums, then the
// saturated output register, which a result passes in that order. While
// out_stall stays low, one request can enter in every cycle; the rate is set
// by the product stage, which takes a new vertex in each cycle. A load takes
// effect for the very next request.
// Reset (rst, synchronous) empties the pipeline and loads the identity
// matrix. When out_stall is high the output holds, and each stage only stops
// once the stage after it is full, so bubbles are filled before in_stall
// rises.
// ----------------------------------------------------------------------------
module affine_vertex_transform #(
  parameter int DATA_WIDTH = avt_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = avt_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            kind,
  input  wire logic [avt_pkg::IDX_WIDTH-1:0]         coef_index,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] coef_value,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] x_in,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] y_in,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] z_in,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] u_in,
  input  wire logic signed [avt_pkg::FIELD_WIDTH-1:0] v_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [avt_pkg::FIELD_WIDTH-1:0]     x_out,
  output logic signed [avt_pkg::FIELD_WIDTH-1:0]     y_out,
  output logic signed [avt_pkg::FIELD_WIDTH-1:0]     z_out,
  output logic signed [avt_pkg::FIELD_WIDTH-1:0]     u_out,
  output logic signed [avt_pkg::FIELD_WIDTH-1:0]     v_out,
  output logic                                       overflow
);
  import avt_pkg::*;

  localparam int W  = (DATA_WIDTH < FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW - FRAC_BITS;
  localparam int AW = SW + 2;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  =
    (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : WMAX;

  // Coefficient store and handshake.
  logic signed [W-1:0] coef [NUM_COEF];
  logic                adv1, adv2, adv3;
  logic                accept, is_xform;
  logic signed [W-1:0] coord [NUM_AXES];

  // Stage 1: products and translation.
  logic                vld1;
  logic signed [PW-1:0] prod_next [NUM_ROWS][NUM_AXES];
  logic signed [PW-1:0] prod1     [NUM_ROWS][NUM_AXES];
  logic signed [W-1:0]  trans1    [NUM_ROWS];
  logic signed [W-1:0]  u1, v1;

  // Stage 2: sums.
  logic                 vld2;
  logic signed [SW-1:0] term     [NUM_ROWS][NUM_AXES];
  logic signed [AW-1:0] acc_next [NUM_ROWS];
  logic signed [AW-1:0] acc2     [NUM_ROWS];
  logic signed [W-1:0]  u2, v2;

  // Stage 3: saturated output register.
  logic                 vld3;
  logic signed [W-1:0]  sat_next [NUM_ROWS];
  logic [NUM_ROWS-1:0]  ovf_next;
  logic signed [W-1:0]  res3     [NUM_ROWS];
  logic                 ovf3;
  logic signed [W-1:0]  u3, v3;

  // A stage moves when it is empty or the stage after it moves.
  assign adv3     = !vld3 || !out_stall;
  assign adv2     = !vld2 || adv3;
  assign adv1     = !vld1 || adv2;
  assign in_stall = !adv1;
  assign accept   = in_valid && adv1;
  assign is_xform = (kind == KIND_POINT) || (kind == KIND_VECTOR);

  assign coord[0] = x_in[W-1:0];
  assign coord[1] = y_in[W-1:0];
  assign coord[2] = z_in[W-1:0];

  // Loads write at acceptance, and products are formed from the store in the
  // same cycle, so every request sees exactly the loads accepted before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= ((i / ROW_LEN) == (i % ROW_LEN)) ? ONE : '0;
      end
    end else if (accept && kind == KIND_LOAD) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        if (coef_index == IDX_WIDTH'(i)) begin
          coef[i] <= coef_value[W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        prod_next[r][c] = PW'(coef[r*ROW_LEN + c]) * PW'(coord[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv1) begin
      vld1 <= accept && is_xform;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      prod1 <= prod_next;
      for (int r = 0; r < NUM_ROWS; r++) begin
        trans1[r] <= (kind == KIND_POINT) ? coef[r*ROW_LEN + NUM_AXES] : '0;
      end
      u1 <= u_in[W-1:0];
      v1 <= v_in[W-1:0];
    end
  end

  // The arithmetic shift drops the fraction bits, rounding toward minus
  // infinity; the sum is kept at full width so only the end result saturates.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        term[r][c] = SW'(prod1[r][c] >>> FRAC_BITS);
      end
      acc_next[r] = AW'(term[r][0]) + AW'(term[r][1]) + AW'(term[r][2])
                  + AW'(trans1[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv2) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      acc2 <= acc_next;
      u2   <= u1;
      v2   <= v1;
    end
  end

  // A sum fits the word when all bits from the word's sign bit upward agree.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      ovf_next[r] = !((&acc2[r][AW-1:W-1]) || !(|acc2[r][AW-1:W-1]));
      if (ovf_next[r]) begin
        sat_next[r] = acc2[r][AW-1] ? WMIN : WMAX;
      end else begin
        sat_next[r] = acc2[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (adv3) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      res3 <= sat_next;
      ovf3 <= |ovf_next;
      u3   <= u2;
      v3   <= v2;
    end
  end

  assign out_valid = vld3;
  assign x_out     = FIELD_WIDTH'(res3[0]);
  assign y_out     = FIELD_WIDTH'(res3[1]);
  assign z_out     = FIELD_WIDTH'(res3[2]);
  assign u_out     = FIELD_WIDTH'(u3);
  assign v_out     = FIELD_WIDTH'(v3);
  assign overflow  = ovf3;

endmodule
`default_nettype wire

/* rtl/avt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avt_port_checks
// Port-level checks for the affine vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module avt_port_checks #(
  parameter int DATA_WIDTH = avt_pkg::DEF_DATA_WIDTH
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [1:0]                       kind,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [avt_pkg::FIELD_WIDTH-1:0]  x_out,
  input wire logic [avt_pkg::FIELD_WIDTH-1:0]  y_out,
  input wire logic [avt_pkg::FIELD_WIDTH-1:0]  z_out,
  input wire logic                             overflow
);
  import avt_pkg::*;

  localparam int W = (DATA_WIDTH < FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
  localparam longint SMAXL = (longint'(1) << (W - 1)) - 1;
  localparam logic [FIELD_WIDTH-1:0] SMAX = FIELD_WIDTH'(SMAXL);
  localparam logic [FIELD_WIDTH-1:0] SMIN = FIELD_WIDTH'(-SMAXL - 1);

  logic xform_req;
  assign xform_req = in_valid && !in_stall
                  && (kind == KIND_POINT || kind == KIND_VECTOR);

  // A result waiting under stall stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(x_out) && $stable(y_out) && $stable(z_out)))
    else $error("result changed while stalled");

  // The input is only held back when every stage is full and the output stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised without back pressure");

  // With no back pressure a transform request reaches the output on time.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    xform_req ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("transform result missing after pipeline latency");

  // A flagged result has at least one component at a range limit.
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (x_out == SMAX || x_out == SMIN || y_out == SMAX
                                 || y_out == SMIN || z_out == SMAX || z_out == SMIN))
    else $error("overflow set with no saturated component");

endmodule

bind affine_vertex_transform avt_port_checks #(.DATA_WIDTH(DATA_WIDTH)) u_avt_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .x_out     (x_out),
  .y_out     (y_out),
  .z_out     (z_out),
  .overflow  (overflow)
);
`default_nettype wire

/* bench/avt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// avt_checker
// Watches both channels of the affine vertex transform. It keeps its own
// copy of the coefficient matrix, works out the expected vertex for every
// accepted transform request, and compares each accepted result field by
// field against the oldest expected vertex.
// ----------------------------------------------------------------------------
module avt_checker
  import avt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [IDX_WIDTH-1:0]          coef_index,
  input  logic signed [FIELD_WIDTH-1:0] coef_value,
  input  logic signed [FIELD_WIDTH-1:0] x_in,
  input  logic signed [FIELD_WIDTH-1:0] y_in,
  input  logic signed [FIELD_WIDTH-1:0] z_in,
  input  logic signed [FIELD_WIDTH-1:0] u_in,
  input  logic signed [FIELD_WIDTH-1:0] v_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [FIELD_WIDTH-1:0] x_out,
  input  logic signed [FIELD_WIDTH-1:0] y_out,
  input  logic signed [FIELD_WIDTH-1:0] z_out,
  input  logic signed [FIELD_WIDTH-1:0] u_out,
  input  logic signed [FIELD_WIDTH-1:0] v_out,
  input  logic                          overflow,
  output int                            fail_count,
  output int                            outstanding
);

  localparam int FRAC = DEF_FRAC_BITS;
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;
  localparam logic signed [FIELD_WIDTH-1:0] UNITY = 1 << FRAC;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] x;
    logic signed [FIELD_WIDTH-1:0] y;
    logic signed [FIELD_WIDTH-1:0] z;
    logic signed [FIELD_WIDTH-1:0] u;
    logic signed [FIELD_WIDTH-1:0] v;
    logic                          ovf;
  } vertex_t;

  logic signed [FIELD_WIDTH-1:0] coef_store [NUM_COEF];
  vertex_t expected_vertices [$];
  int mismatches = 0;

  assign fail_count = mismatches;

  // Exact product, then the fraction bits are dropped (floor toward minus
  // infinity, since the shift is arithmetic).
  function automatic logic signed [63:0] scaled_product(logic signed [FIELD_WIDTH-1:0] a,
                                                        logic signed [FIELD_WIDTH-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic vertex_t transform_vertex(logic [1:0] k,
                                               logic signed [FIELD_WIDTH-1:0] x,
                                               logic signed [FIELD_WIDTH-1:0] y,
                                               logic signed [FIELD_WIDTH-1:0] z,
                                               logic signed [FIELD_WIDTH-1:0] u,
                                               logic signed [FIELD_WIDTH-1:0] v);
    vertex_t r;
    logic signed [63:0] acc;
    logic signed [FIELD_WIDTH-1:0] axis [NUM_AXES];
    r.u = u;
    r.v = v;
    r.ovf = 1'b0;
    for (int row = 0; row < NUM_ROWS; row++) begin
      acc = scaled_product(coef_store[row*ROW_LEN], x)
          + scaled_product(coef_store[row*ROW_LEN+1], y)
          + scaled_product(coef_store[row*ROW_LEN+2], z);
      // Only points pick up the translation column.
      if (k == KIND_POINT) begin
        acc = acc + coef_store[row*ROW_LEN+3];
      end
      if (acc > WORD_MAX) begin
        acc = WORD_MAX;
        r.ovf = 1'b1;
      end else if (acc < WORD_MIN) begin
        acc = WORD_MIN;
        r.ovf = 1'b1;
      end
      axis[row] = acc[FIELD_WIDTH-1:0];
    end
    r.x = axis[0];
    r.y = axis[1];
    r.z = axis[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_vertex(vertex_t want);
    if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
    if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
    if (z_out !== want.z) report_mismatch("z_out", z_out, want.z);
    if (u_out !== want.u) report_mismatch("u_out", u_out, want.u);
    if (v_out !== want.v) report_mismatch("v_out", v_out, want.v);
    if (overflow !== want.ovf) report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (coef_store[i]) coef_store[i] = '0;
      for (int r = 0; r < NUM_ROWS; r++) coef_store[r*ROW_LEN + r] = UNITY;
      expected_vertices.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("x_out of a result nobody asked for", x_out, '0);
        end else begin
          check_vertex(expected_vertices.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_LOAD: begin
            if (coef_index < NUM_COEF) coef_store[coef_index] = coef_value;
          end
          KIND_POINT, KIND_VECTOR: begin
            expected_vertices.push_back(transform_vertex(kind, x_in, y_in, z_in, u_in, v_in));
          end
          default: ;
        endcase
      end
    end
    outstanding = expected_vertices.size();
  end

endmodule

/* bench/tb_affine_vertex_transform.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_vertex_transform
// Drives coefficient loads, point and vector requests into the affine vertex
// transform: a directed opening on the edge cases, then random traffic with
// random gaps and output stalls, including one long output hold-off. The
// checker beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_affine_vertex_transform;
  import avt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [FIELD_WIDTH-1:0] WMAX  = 32'sh7fffffff;
  localparam logic signed [FIELD_WIDTH-1:0] WMIN  = 32'sh80000000;
  localparam logic signed [FIELD_WIDTH-1:0] UNITY = 32'sh00010000;
  localparam int HOLD_CYCLES = 40;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    kind = KIND_LOAD;
  logic [IDX_WIDTH-1:0]          coef_index = '0;
  logic signed [FIELD_WIDTH-1:0] coef_value = '0;
  logic signed [FIELD_WIDTH-1:0] x_in = '0;
  logic signed [FIELD_WIDTH-1:0] y_in = '0;
  logic signed [FIELD_WIDTH-1:0] z_in = '0;
  logic signed [FIELD_WIDTH-1:0] u_in = '0;
  logic signed [FIELD_WIDTH-1:0] v_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [FIELD_WIDTH-1:0] x_out;
  logic signed [FIELD_WIDTH-1:0] y_out;
  logic signed [FIELD_WIDTH-1:0] z_out;
  logic signed [FIELD_WIDTH-1:0] u_out;
  logic signed [FIELD_WIDTH-1:0] v_out;
  logic                          overflow;
  int                            fail_count;
  int                            outstanding;

  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_served = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  affine_vertex_transform u_dut (.*);

  avt_checker u_checker (.*);

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic signed [FIELD_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return WMAX;
          1:       return WMIN;
          2:       return '0;
          3:       return -1;
          default: return UNITY;
        endcase
      end
      1, 2, 3: return $urandom;
      // Values within +-16.0 keep most sums clear of saturation.
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  task automatic send_request(logic [1:0] k, logic [IDX_WIDTH-1:0] idx,
                              logic signed [FIELD_WIDTH-1:0] cval,
                              logic signed [FIELD_WIDTH-1:0] x,
                              logic signed [FIELD_WIDTH-1:0] y,
                              logic signed [FIELD_WIDTH-1:0] z,
                              logic signed [FIELD_WIDTH-1:0] u,
                              logic signed [FIELD_WIDTH-1:0] v);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind       <= k;
    coef_index <= idx;
    coef_value <= cval;
    x_in       <= x;
    y_in       <= y;
    z_in       <= z;
    u_in       <= u;
    v_in       <= v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic load_coef(int idx, logic signed [FIELD_WIDTH-1:0] val);
    send_request(KIND_LOAD, IDX_WIDTH'(idx), val, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
  endtask

  task automatic send_vertex(logic [1:0] k, logic signed [FIELD_WIDTH-1:0] x,
                             logic signed [FIELD_WIDTH-1:0] y,
                             logic signed [FIELD_WIDTH-1:0] z,
                             logic signed [FIELD_WIDTH-1:0] u,
                             logic signed [FIELD_WIDTH-1:0] v);
    send_request(k, IDX_WIDTH'($urandom), $urandom, x, y, z, u, v);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      load_coef(($urandom_range(0, 9) == 0) ? $urandom_range(NUM_COEF, 15)
                                            : $urandom_range(0, NUM_COEF - 1), rand_word());
    end else if (r < 20) begin
      send_request(KIND_UNUSED, IDX_WIDTH'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
    end else begin
      send_vertex((r < 60) ? KIND_POINT : KIND_VECTOR, rand_word(), rand_word(), rand_word(),
                  $urandom, $urandom);
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_off_served) begin
      hold_off_served = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (receiver_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix passes the extremes straight through.
    send_vertex(KIND_POINT, WMAX, WMIN, 0, WMIN, WMAX);
    send_vertex(KIND_VECTOR, WMIN, WMAX, -1, 0, -1);
    // The unused kind and out-of-range loads must leave the matrix alone.
    send_request(KIND_UNUSED, 4'hf, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
    load_coef(12, WMAX);
    load_coef(15, WMIN);
    send_vertex(KIND_POINT, 1, -1, UNITY, 1, -1);
    // Translation saturates a point upward but is left out of a vector.
    load_coef(3, WMAX);
    send_vertex(KIND_POINT, WMAX, 0, 0, 0, 0);
    send_vertex(KIND_VECTOR, WMAX, 0, 0, 0, 0);
    load_coef(7, WMIN);
    send_vertex(KIND_POINT, 0, WMIN, 0, 0, 0);
    // A tiny negative product must round down to -1, not to zero.
    load_coef(1, -1);
    send_vertex(KIND_POINT, 0, 1, 0, 0, 0);
    // Largest product of all: min times min.
    load_coef(0, WMIN);
    send_vertex(KIND_POINT, WMIN, WMIN, WMIN, WMIN, WMIN);
    load_coef(10, 0);
    load_coef(11, WMAX);
    send_vertex(KIND_VECTOR, -1, -1, -1, WMAX, WMIN);
    send_vertex(KIND_POINT, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 6; phase++) begin
      sender_idle = (phase % 3) != 0;
      receiver_idle <= (phase % 2) == 1;
      repeat (200) random_request();
      if (phase == 2) begin
        // Back-to-back requests against a long output hold-off.
        sender_idle = 1'b0;
        hold_off_req <= 1'b1;
        repeat (30) send_vertex(KIND_POINT, rand_word(), rand_word(), rand_word(), $urandom,
                                $urandom);
      end
    end
    in_valid <= 1'b0;
    receiver_idle <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
